// File: src/drhs_pkg.sv
// ----------------------------------------------------------------------------
// drhs_pkg: shared types and constants of the double rolling hash block
// Holds the two prime moduli and their bases, command codes, sequencer states
// and the request format of the shared modular multiplier.
// ----------------------------------------------------------------------------
package drhs_pkg;

  localparam int VAL_W = 31;
  localparam int IDX_W = 11;
  localparam int BYTE_W = 8;

  localparam logic [VAL_W-1:0] MOD_A  = 31'd2147483647;
  localparam logic [VAL_W-1:0] MOD_B  = 31'd2147483629;
  localparam logic [VAL_W-1:0] BASE_A = 31'd2147483634;
  localparam logic [VAL_W-1:0] BASE_B = 31'd2147483627;

  // 2^31 mod the prime, used to fold the high part of a product back in
  localparam logic [4:0] FOLD_A = 5'd1;
  localparam logic [4:0] FOLD_B = 5'd19;

  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_MUL,
    S_MWAIT,
    S_WR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic              sel;
    logic [BYTE_W-1:0] addend;
  } mm_req_t;

endpackage

// File: src/drhs_ram.sv
// ----------------------------------------------------------------------------
// drhs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module drhs_ram #(
  parameter int W = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/drhs_mulmod.sv
// ----------------------------------------------------------------------------
// drhs_mulmod: shared modular multiplier
// Computes (x * y + addend) mod the selected prime in three stages: product,
// first fold of the high half, second fold with addend and final correction.
// ----------------------------------------------------------------------------
module drhs_mulmod (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  drhs_pkg::mm_req_t   req,
  output logic                done,
  output logic [30:0]         result
);
  import drhs_pkg::*;

  logic [61:0]       prod_r, prod_nxt;
  logic [36:0]       fold_r, fold_nxt;
  logic [VAL_W-1:0]  res_r, res_nxt;
  logic              sel1_r, sel2_r;
  logic [BYTE_W-1:0] add1_r, add2_r;
  logic [2:0]        vld_r, vld_nxt;

  logic [4:0]        c1, c2;
  logic [VAL_W-1:0]  m2;
  logic [31:0]       sum2;

  always_comb begin
    prod_nxt = 62'(req.x) * 62'(req.y);

    c1       = (sel1_r == SEL_B) ? FOLD_B : FOLD_A;
    fold_nxt = 37'(prod_r[30:0]) + 37'(prod_r[61:31]) * 37'(c1);

    // value stays below twice the prime: one subtract is enough
    c2      = (sel2_r == SEL_B) ? FOLD_B : FOLD_A;
    m2      = (sel2_r == SEL_B) ? MOD_B : MOD_A;
    sum2    = 32'(fold_r[30:0]) + 32'(fold_r[36:31]) * 32'(c2) + 32'(add2_r);
    res_nxt = (sum2 >= {1'b0, m2}) ? 31'(sum2 - {1'b0, m2}) : sum2[30:0];

    vld_nxt = {vld_r[1:0], start};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sel1_r <= req.sel;
    add1_r <= req.addend;
    fold_r <= fold_nxt;
    sel2_r <= sel1_r;
    add2_r <= add1_r;
    res_r  <= res_nxt;
  end

  assign done   = vld_r[2];
  assign result = res_r;

endmodule

// File: src/double_rolling_hash_substring_top.sv
// ----------------------------------------------------------------------------
// double_rolling_hash_substring_top: double polynomial rolling hash
// Keeps prefix hashes and base powers for two prime moduli and answers
// substring hash queries over a half-open index range.
//
//   channel | ports       | tdata (low bit up)             | tuser
//   --------+-------------+--------------------------------+----------------
//   input   | in_t*       | char_byte, left, right, pad    | command
//   result  | out_t*      | hash_a, hash_b, pad            | range_error
//
// Appends and valid queries are paced by the one shared modular multiplier
// (4 products per append, 2 per query) and the single read port of the hash
// RAM; a clear or a rejected query skips the multiplier. Reset clears length
// and control only; entry 0 of each store is supplied as a constant, so no
// clearing pass is needed. A result waits in the output register while the
// next transaction is taken; a query that finishes before it is taken holds.
// ----------------------------------------------------------------------------
module double_rolling_hash_substring_top #(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_byte[7:0], left[18:8], right[29:19], zero pad
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // hash_a[30:0], hash_b[61:31], zero pad
  output logic        out_tuser   // range_error
);
  import drhs_pkg::*;

  localparam int DEPTH = MAX_LEN + 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = LW;
  localparam int CW = (LW > IDX_W) ? LW : IDX_W;

  state_t state_r, state_nxt;

  logic [1:0]        cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [VAL_W-1:0]  ha_r, ha_nxt, hb_r, hb_nxt;
  logic [VAL_W-1:0]  pa_r, pa_nxt, pb_r, pb_nxt;
  logic [VAL_W-1:0]  hia_r, hia_nxt, hib_r, hib_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_ha_r, out_ha_nxt, out_hb_r, out_hb_nxt;
  logic              out_err_r, out_err_nxt;

  logic              accept;
  logic              is_append;
  logic              full;
  logic              range_bad;
  logic              last_op;
  logic              out_free;
  logic [IDX_W-1:0]  span;
  logic [VAL_W-1:0]  sub_a, sub_b;

  logic              hash_rd_en, pow_rd_en, ram_wr_en;
  logic [AW-1:0]     hash_rd_addr, pow_rd_addr, wr_addr;
  logic [2*VAL_W-1:0] hash_q, pow_q;

  logic              mm_start, mm_done;
  mm_req_t           mm_req;
  logic [VAL_W-1:0]  mm_result;

  assign accept    = in_tvalid && in_tready;
  assign is_append = (cmd_r == CMD_APPEND);
  assign full      = (len_r == LW'(MAX_LEN));
  assign span      = hi_r - lo_r;
  assign range_bad = (lo_r > hi_r) || (CW'(hi_r) > CW'(len_r));
  assign last_op   = is_append ? (k_r == 2'd3) : (k_r == 2'd1);
  assign out_free  = !out_valid_r || out_tready;
  assign wr_addr   = AW'(len_r) + AW'(1);

  // H[hi] - H[lo] * P[span], kept in 0 .. prime-1
  assign sub_a = (hia_r >= ha_r) ? (hia_r - ha_r)
                                 : 31'(32'(hia_r) + 32'(MOD_A) - 32'(ha_r));
  assign sub_b = (hib_r >= hb_r) ? (hib_r - hb_r)
                                 : 31'(32'(hib_r) + 32'(MOD_B) - 32'(hb_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == CMD_QUERY || (in_tuser == CMD_APPEND && !full)) begin
            state_nxt = S_RD0;
          end
        end
      end
      S_RD0: begin
        if (!is_append && range_bad) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        state_nxt = is_append ? S_MUL : S_RD2;
      end
      S_RD2: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (mm_done) begin
          if (!last_op) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = is_append ? S_WR : S_OUT;
          end
        end
      end
      S_WR: begin
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_tready    = 1'b0;
    hash_rd_en   = 1'b0;
    pow_rd_en    = 1'b0;
    hash_rd_addr = AW'(len_r);
    pow_rd_addr  = AW'(len_r);
    ram_wr_en    = 1'b0;
    mm_start     = 1'b0;
    mm_req.x     = ha_r;
    mm_req.y     = BASE_A;
    mm_req.sel   = k_r[0];
    mm_req.addend = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_RD0: begin
        hash_rd_en = 1'b1;
        pow_rd_en  = 1'b1;
        if (!is_append) begin
          hash_rd_addr = AW'(lo_r);
          pow_rd_addr  = AW'(span);
        end
      end
      S_RD1: begin
        if (!is_append) begin
          hash_rd_en   = 1'b1;
          hash_rd_addr = AW'(hi_r);
        end
      end
      S_MUL: begin
        mm_start = 1'b1;
        case (k_r)
          2'd0: mm_req.x = ha_r;
          2'd1: mm_req.x = hb_r;
          2'd2: mm_req.x = pa_r;
          default: mm_req.x = pb_r;
        endcase
        if (is_append) begin
          mm_req.y = (k_r[0] == SEL_B) ? BASE_B : BASE_A;
          if (!k_r[1]) begin
            mm_req.addend = byte_r;
          end
        end else begin
          mm_req.y = (k_r[0] == SEL_B) ? pb_r : pa_r;
        end
      end
      S_WR: begin
        ram_wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    cmd_nxt       = cmd_r;
    byte_nxt      = byte_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    ha_nxt        = ha_r;
    hb_nxt        = hb_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    hia_nxt       = hia_r;
    hib_nxt       = hib_r;
    err_nxt       = err_r;
    out_ha_nxt    = out_ha_r;
    out_hb_nxt    = out_hb_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_tuser;
          byte_nxt = in_tdata[7:0];
          lo_nxt   = in_tdata[18:8];
          hi_nxt   = in_tdata[29:19];
          if (in_tuser == CMD_CLEAR) begin
            len_nxt = '0;
          end
        end
      end
      S_RD0: begin
        err_nxt = !is_append && range_bad;
        k_nxt   = '0;
      end
      S_RD1: begin
        // entry 0 is never written: supply its reset value
        if ((is_append ? (len_r == '0) : (lo_r == '0))) begin
          ha_nxt = '0;
          hb_nxt = '0;
        end else begin
          ha_nxt = hash_q[VAL_W-1:0];
          hb_nxt = hash_q[2*VAL_W-1:VAL_W];
        end
        if ((is_append ? (len_r == '0) : (span == '0))) begin
          pa_nxt = 31'd1;
          pb_nxt = 31'd1;
        end else begin
          pa_nxt = pow_q[VAL_W-1:0];
          pb_nxt = pow_q[2*VAL_W-1:VAL_W];
        end
      end
      S_RD2: begin
        if (hi_r == '0) begin
          hia_nxt = '0;
          hib_nxt = '0;
        end else begin
          hia_nxt = hash_q[VAL_W-1:0];
          hib_nxt = hash_q[2*VAL_W-1:VAL_W];
        end
      end
      S_MWAIT: begin
        if (mm_done) begin
          case (k_r)
            2'd0: ha_nxt = mm_result;
            2'd1: hb_nxt = mm_result;
            2'd2: pa_nxt = mm_result;
            default: pb_nxt = mm_result;
          endcase
          k_nxt = k_r + 2'd1;
        end
      end
      S_WR: begin
        len_nxt = len_r + LW'(1);
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          out_ha_nxt    = err_r ? '0 : sub_a;
          out_hb_nxt    = err_r ? '0 : sub_b;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    byte_r    <= byte_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    ha_r      <= ha_nxt;
    hb_r      <= hb_nxt;
    pa_r      <= pa_nxt;
    pb_r      <= pb_nxt;
    hia_r     <= hia_nxt;
    hib_r     <= hib_nxt;
    err_r     <= err_nxt;
    out_ha_r  <= out_ha_nxt;
    out_hb_r  <= out_hb_nxt;
    out_err_r <= out_err_nxt;
  end

  drhs_ram #(
    .W     (2 * VAL_W),
    .DEPTH (DEPTH)
  ) u_hash_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_addr),
    .wr_data ({hb_r, ha_r}),
    .rd_en   (hash_rd_en),
    .rd_addr (hash_rd_addr),
    .rd_data (hash_q)
  );

  drhs_ram #(
    .W     (2 * VAL_W),
    .DEPTH (DEPTH)
  ) u_pow_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_addr),
    .wr_data ({pb_r, pa_r}),
    .rd_en   (pow_rd_en),
    .rd_addr (pow_rd_addr),
    .rd_data (pow_q)
  );

  drhs_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .req    (mm_req),
    .done   (mm_done),
    .result (mm_result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_hb_r, out_ha_r};
  assign out_tuser  = out_err_r;

endmodule
